### design/ultrasonic_echo_ranger_assert.svh
// Assertion macros used by the ultrasonic echo ranger sequencer.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define UER_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ultrasonic echo ranger: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define UER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ultrasonic echo ranger: assertion failed");

`endif

### design/uer_pkg.sv
// Types and constants shared by the ultrasonic echo ranger.
package uer_pkg;

  localparam int TMO_W      = 20;
  localparam int SPD_W      = 13;
  localparam int PULSE_W    = 20;
  localparam int DIST_W     = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int TRIG_CNT_W = 4;

  // Distance is width * speed / DIST_DIV in hundredths of a centimeter.
  localparam int DIST_DIV  = 2000;
  localparam int SPD_Q_W   = 3;
  localparam int SPD_REM_W = 11;

  localparam logic [TMO_W-1:0]     TIMEOUT_RST = TMO_W'(30000);
  localparam int                   SPEED_RST   = 3432;
  localparam logic [SPD_Q_W-1:0]   SPD_Q_RST   = SPD_Q_W'(SPEED_RST / DIST_DIV);
  localparam logic [SPD_REM_W-1:0] SPD_REM_RST = SPD_REM_W'(SPEED_RST % DIST_DIV);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_WAIT_FALL = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_SPEED   = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [TMO_W-1:0]     timeout;
    logic [SPD_Q_W-1:0]   spd_q;
    logic [SPD_REM_W-1:0] spd_rem;
  } uer_cfg_t;

  typedef struct packed {
    logic               trig;
    logic               busy;
    logic               done;
    logic               status;
    logic [PULSE_W-1:0] pulse;
    logic [DIST_W-1:0]  distance;
  } step_res_t;

endpackage

### design/uer_in_if.sv
// Input channel: one sample tick with start request and echo level.
interface uer_in_if import uer_pkg::*; ();
  logic valid;
  logic ready;
  logic start_request;
  logic echo_level;

  modport source (output valid, output start_request, output echo_level, input ready);
  modport sink   (input valid, input start_request, input echo_level, output ready);
endinterface

### design/uer_out_if.sv
// Result channel: trigger level, status and measurement of one tick.
interface uer_out_if import uer_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               trigger_out;
  logic               busy_res;
  logic               done_res;
  logic               status_code;
  logic [PULSE_W-1:0] pulse_ticks;
  logic [DIST_W-1:0]  distance_centi_cm;

  modport source (output valid, output trigger_out, output busy_res, output done_res,
                  output status_code, output pulse_ticks, output distance_centi_cm,
                  input ready);
  modport sink   (input valid, input trigger_out, input busy_res, input done_res,
                  input status_code, input pulse_ticks, input distance_centi_cm,
                  output ready);
endinterface

### design/uer_cfg_if.sv
// Configuration write channel: register index and write data.
interface uer_cfg_if import uer_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/uer_cfg.sv
// Configuration registers; the speed is stored split by the distance divisor.
module uer_cfg import uer_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  uer_cfg_if.sink  cfg_ch,
  output uer_cfg_t cfg
);

  logic [TMO_W-1:0]     timeout_r, timeout_nxt;
  logic [SPD_Q_W-1:0]   spd_q_r, spd_q_nxt;
  logic [SPD_REM_W-1:0] spd_rem_r, spd_rem_nxt;
  logic [SPD_W-1:0]     spd_new;
  logic [SPD_Q_W-1:0]   q_new;
  logic [SPD_W-1:0]     rem_new;

  assign cfg_ch.ready = 1'b1;
  assign spd_new      = cfg_ch.data[SPD_W-1:0];

  // The speed is below five times the divisor, so a short threshold chain
  // gives quotient and remainder.
  always_comb begin
    if (spd_new >= SPD_W'(4 * DIST_DIV)) begin
      q_new   = SPD_Q_W'(4);
      rem_new = spd_new - SPD_W'(4 * DIST_DIV);
    end else if (spd_new >= SPD_W'(3 * DIST_DIV)) begin
      q_new   = SPD_Q_W'(3);
      rem_new = spd_new - SPD_W'(3 * DIST_DIV);
    end else if (spd_new >= SPD_W'(2 * DIST_DIV)) begin
      q_new   = SPD_Q_W'(2);
      rem_new = spd_new - SPD_W'(2 * DIST_DIV);
    end else if (spd_new >= SPD_W'(DIST_DIV)) begin
      q_new   = SPD_Q_W'(1);
      rem_new = spd_new - SPD_W'(DIST_DIV);
    end else begin
      q_new   = '0;
      rem_new = spd_new;
    end
  end

  always_comb begin
    timeout_nxt = timeout_r;
    spd_q_nxt   = spd_q_r;
    spd_rem_nxt = spd_rem_r;
    if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_TIMEOUT: timeout_nxt = cfg_ch.data[TMO_W-1:0];
        CFG_SPEED: begin
          spd_q_nxt   = q_new;
          spd_rem_nxt = rem_new[SPD_REM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      spd_q_r   <= SPD_Q_RST;
      spd_rem_r <= SPD_REM_RST;
    end else begin
      timeout_r <= timeout_nxt;
      spd_q_r   <= spd_q_nxt;
      spd_rem_r <= spd_rem_nxt;
    end
  end

  assign cfg.timeout = timeout_r;
  assign cfg.spd_q   = spd_q_r;
  assign cfg.spd_rem = spd_rem_r;

endmodule

### design/uer_step.sv
// Measurement sequencer: trigger pulse, echo waits, deadline and running distance.
module uer_step import uer_pkg::*; #(
  parameter int TRIGGER_LOW_TICKS  = 2,
  parameter int TRIGGER_HIGH_TICKS = 10,
  parameter int COUNT_BITS         = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  logic      start_request,
  input  logic      echo_level,
  input  uer_cfg_t  cfg,
  output step_res_t res
);

`include "ultrasonic_echo_ranger_assert.svh"

  localparam int CMP_W = (COUNT_BITS > TMO_W) ? COUNT_BITS : TMO_W;
  localparam int EXT_W = (CMP_W > PULSE_W) ? CMP_W : PULSE_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [TRIG_CNT_W-1:0] LOW_END  = TRIG_CNT_W'(TRIGGER_LOW_TICKS);
  localparam logic [TRIG_CNT_W-1:0] HIGH_END = TRIG_CNT_W'(TRIGGER_HIGH_TICKS);

  phase_t                  phase_r, phase_nxt, phase_cur;
  logic [TRIG_CNT_W-1:0]   tc_r, tc_nxt, tc_inc;
  logic [COUNT_BITS-1:0]   el_r, el_nxt;
  logic [COUNT_BITS-1:0]   wc_r, wc_nxt, wc_inc;
  logic [DIST_W-1:0]       dq_r, dq_nxt, dq_inc;
  logic [SPD_REM_W-1:0]    dr_r, dr_nxt, dr_inc;
  logic [SPD_REM_W:0]      dr_sum;
  logic                    dr_carry;
  logic                    wc_sat;
  logic                    timed_out;
  logic [EXT_W-1:0]        wc_ext;

  // The distance is kept as quotient and remainder of width * speed / divisor,
  // advanced by one speed step whenever the width count grows.
  assign wc_sat   = (wc_r == CNT_MAX);
  assign wc_inc   = wc_sat ? wc_r : wc_r + 1'b1;
  assign dr_sum   = {1'b0, dr_r} + {1'b0, cfg.spd_rem};
  assign dr_carry = (dr_sum >= (SPD_REM_W + 1)'(DIST_DIV));
  assign dr_inc   = wc_sat ? dr_r
                  : (dr_carry ? SPD_REM_W'(dr_sum - (SPD_REM_W + 1)'(DIST_DIV))
                              : dr_sum[SPD_REM_W-1:0]);
  assign dq_inc   = wc_sat ? dq_r
                  : dq_r + DIST_W'(cfg.spd_q) + DIST_W'(dr_carry);
  assign tc_inc   = tc_r + 1'b1;
  assign timed_out = (CMP_W'(el_r) >= CMP_W'(cfg.timeout));
  assign wc_ext    = EXT_W'(wc_inc);

  always_comb begin
    case (phase_r)
      PH_TRIG_LOW, PH_TRIG_HIGH, PH_WAIT_RISE, PH_WAIT_FALL: phase_cur = phase_r;
      default: phase_cur = PH_IDLE;
    endcase
  end

  // Next state and counters.
  always_comb begin
    phase_nxt = phase_cur;
    tc_nxt    = tc_r;
    el_nxt    = el_r;
    wc_nxt    = wc_r;
    dq_nxt    = dq_r;
    dr_nxt    = dr_r;
    case (phase_cur)
      PH_IDLE: begin
        if (start_request) begin
          if (TRIG_CNT_W'(1) >= LOW_END) begin
            phase_nxt = PH_TRIG_HIGH;
            tc_nxt    = '0;
          end else begin
            phase_nxt = PH_TRIG_LOW;
            tc_nxt    = TRIG_CNT_W'(1);
          end
        end
      end
      PH_TRIG_LOW: begin
        if (tc_inc >= LOW_END) begin
          phase_nxt = PH_TRIG_HIGH;
          tc_nxt    = '0;
        end else begin
          tc_nxt = tc_inc;
        end
      end
      PH_TRIG_HIGH: begin
        if (tc_inc >= HIGH_END) begin
          phase_nxt = PH_WAIT_RISE;
          tc_nxt    = '0;
          el_nxt    = '0;
          wc_nxt    = '0;
          dq_nxt    = '0;
          dr_nxt    = '0;
        end else begin
          tc_nxt = tc_inc;
        end
      end
      PH_WAIT_RISE: begin
        if (echo_level) begin
          phase_nxt = PH_WAIT_FALL;
          wc_nxt    = '0;
          dq_nxt    = '0;
          dr_nxt    = '0;
        end else if (timed_out) begin
          phase_nxt = PH_IDLE;
        end
        el_nxt = (el_r == CNT_MAX) ? el_r : el_r + 1'b1;
      end
      PH_WAIT_FALL: begin
        if (!echo_level || timed_out) begin
          phase_nxt = PH_IDLE;
        end else begin
          wc_nxt = wc_inc;
          dq_nxt = dq_inc;
          dr_nxt = dr_inc;
        end
        el_nxt = (el_r == CNT_MAX) ? el_r : el_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Outputs of this tick.
  always_comb begin
    res        = '0;
    res.busy   = (phase_nxt != PH_IDLE);
    case (phase_cur)
      PH_TRIG_HIGH: res.trig = 1'b1;
      PH_WAIT_RISE: begin
        if (!echo_level && timed_out) begin
          res.done   = 1'b1;
          res.status = 1'b1;
        end
      end
      PH_WAIT_FALL: begin
        if (!echo_level) begin
          res.done     = 1'b1;
          res.pulse    = wc_ext[PULSE_W-1:0];
          res.distance = dq_inc;
        end else if (timed_out) begin
          res.done   = 1'b1;
          res.status = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tc_r    <= '0;
      el_r    <= '0;
      wc_r    <= '0;
      dq_r    <= '0;
      dr_r    <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tc_r    <= tc_nxt;
      el_r    <= el_nxt;
      wc_r    <= wc_nxt;
      dq_r    <= dq_nxt;
      dr_r    <= dr_nxt;
    end
  end

  `UER_ASSERT_NEXT(a_done_to_idle, step_en && res.done, phase_r == PH_IDLE)
  `UER_ASSERT_IMPL(a_result_needs_done, res.status || (res.pulse != '0), res.done)
  `UER_ASSERT_IMPL(a_trig_in_high, res.trig, phase_r == PH_TRIG_HIGH)
  `UER_ASSERT_NEXT(a_hold_without_step, !step_en, $stable(phase_r) && $stable(el_r))

endmodule

### design/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level. Each input transaction is one microsecond
// tick and yields exactly one result transaction. A new tick is accepted every
// clock cycle unless the result channel stalls; a result is offered once its
// tick has passed the input register and the result register around the
// single sequencer step. Back-pressure on the result channel holds the
// pipeline: while a finished result waits in the result register, one more
// tick is taken into an empty input register and then the input stalls until
// the result is taken. The distance is accumulated as a running quotient and
// remainder while the echo is high, so no multiplier or divider sits in the
// path. Configuration writes complete in the cycle they are offered and must
// be made while no measurement is in progress.
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int TRIGGER_LOW_TICKS  = 2,
  parameter int TRIGGER_HIGH_TICKS = 10,
  parameter int COUNT_BITS         = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  uer_in_if.sink    in_ch,
  uer_out_if.source out_ch,
  uer_cfg_if.sink   cfg_ch
);

  logic      s1_valid_r;
  logic      s1_start_r;
  logic      s1_echo_r;
  logic      out_valid_r;
  step_res_t out_res_r;
  step_res_t res;
  uer_cfg_t  cfg;
  logic      out_adv;
  logic      s1_ready;
  logic      step_en;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_ready    = !s1_valid_r || out_adv;
  assign step_en     = s1_valid_r && out_adv;
  assign in_ch.ready = s1_ready;

  uer_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  uer_step #(
    .TRIGGER_LOW_TICKS  (TRIGGER_LOW_TICKS),
    .TRIGGER_HIGH_TICKS (TRIGGER_HIGH_TICKS),
    .COUNT_BITS         (COUNT_BITS)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .start_request (s1_start_r),
    .echo_level    (s1_echo_r),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_ready) begin
      s1_start_r <= in_ch.start_request;
      s1_echo_r  <= in_ch.echo_level;
    end
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.trigger_out       = out_res_r.trig;
  assign out_ch.busy_res          = out_res_r.busy;
  assign out_ch.done_res          = out_res_r.done;
  assign out_ch.status_code       = out_res_r.status;
  assign out_ch.pulse_ticks       = out_res_r.pulse;
  assign out_ch.distance_centi_cm = out_res_r.distance;

endmodule
